// ----- rtl/lud_pkg.sv -----
package lud_pkg;
	localparam int DATA_W = 32;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
	localparam logic [1:0] ADDR_ORDER = 2'd0;

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v, output logic ov);
		ov = 1'b0;
		if (v > 64'sh000000007fffffff) begin
			ov = 1'b1;
			return SAT_MAX;
		end
		if (v < -64'sh0000000080000000) begin
			ov = 1'b1;
			return SAT_MIN;
		end
		return v[31:0];
	endfunction
endpackage

// ----- rtl/lud_ram.sv -----
module lud_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/lud_div.sv -----
// Signed 64/32 restoring divider, one quotient bit per cycle, truncation toward zero.
module lud_div import lud_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [63:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [63:0] quo
);
	logic [63:0] n_q, q_q;
	logic [64:0] r_q;
	logic [31:0] d_q;
	logic        neg_q, run_q;
	logic [5:0]  cnt_q;
	logic [64:0] r_sh;

	assign r_sh = {r_q[63:0], n_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				n_q   <= num[63] ? 64'(-num) : num;
				d_q   <= den[31] ? 32'(-den) : den;
				neg_q <= num[63] ^ den[31];
				r_q   <= '0;
				q_q   <= '0;
			end else if (run_q) begin
				n_q <= {n_q[62:0], 1'b0};
				if (r_sh >= {33'd0, d_q}) begin
					r_q <= r_sh - {33'd0, d_q};
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					r_q <= r_sh;
					q_q <= {q_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	assign quo = neg_q ? 64'(-$signed(q_q)) : $signed(q_q);
endmodule

// ----- rtl/lu_decomposition_determinant_top.sv -----
// LU factorization (Doolittle, no pivoting) with determinant.
// Write order (1..MAX_ORDER, address 0) over the APB port while idle; a write
// restarts loading. Present one Q16.16 element per request with start while busy
// is low, row-major. After the last element
// busy stays high while the shared multiply-accumulate unit and a bit-serial
// divider work through the product terms, the L divisions and the determinant
// steps. The combined LU matrix then streams out row-major, each result read
// from memory in S_ORD and presented in S_OUT, each marked by out_valid
// for one cycle; the last carries last_flag, the determinant and the flags.
// The receiver cannot stall. Reset restores order 4 and clears the load count.
module lu_decomposition_determinant_top import lud_pkg::*; #(
	parameter int MAX_ORDER = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] element,
	output logic               out_valid,
	output logic signed [31:0] lu_value,
	output logic [2:0]         row_index,
	output logic [2:0]         col_index,
	output logic               is_lower,
	output logic               last_flag,
	output logic signed [31:0] determinant,
	output logic               zero_pivot,
	output logic               overflow
);
	localparam int AW = 6;

	typedef enum logic [3:0] {
		S_LOAD, S_EL, S_RDA, S_RDB, S_MAC, S_DIFF, S_PIV, S_DIVW, S_WR,
		S_DRD, S_DMUL, S_ORD, S_OUT
	} state_t;
	state_t st_q;

	logic [3:0] order_q;
	logic [3:0] n;
	logic [6:0] cnt_q;
	logic [2:0] lr_q, lc_q, i_q, j_q, k_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] a_q, diff_q, det_q;
	logic pf_q, sat_q;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;
	logic dgo, ddone;
	logic signed [63:0] dnum, dquo;
	logic signed [63:0] prod_q;
	logic ov0, ov1, ov2;
	logic signed [31:0] s0, s1, s2;
	logic signed [31:0] mul_a;
	logic signed [63:0] mul_p;

	assign n = (order_q == 4'd0) ? 4'd1 :
		(order_q > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : order_q;
	assign pready = 1'b1;
	assign prdata = {28'd0, order_q};
	assign busy = (st_q != S_LOAD);

	function automatic logic [AW-1:0] ad(input logic [2:0] r, input logic [2:0] c);
		return AW'({r, c});
	endfunction

	lud_ram #(.WIDTH(32), .DEPTH(64)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign dnum = 64'(diff_q) <<< FRAC_BITS;
	lud_div u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo), .num(dnum), .den($signed(rdata)),
		.done(ddone), .quo(dquo)
	);

	// one multiplier serves both the product terms and the determinant
	assign mul_a = (st_q == S_DMUL) ? det_q : diff_q;
	assign mul_p = mul_a * $signed(rdata);

	logic [2:0] lim;
	assign lim = (i_q <= j_q) ? i_q : j_q;

	always_comb begin
		we = 1'b0;
		waddr = ad(lr_q, lc_q);
		wdata = element;
		raddr = ad(i_q, k_q);
		dgo = 1'b0;
		s0 = sat64(64'(a_q) - acc_q, ov0);
		s1 = sat64(prod_q >>> FRAC_BITS, ov1);
		s2 = sat64(dquo, ov2);
		case (st_q)
			S_LOAD: we = start;
			S_RDA: raddr = ad(i_q, k_q);
			S_RDB: raddr = ad(k_q, j_q);
			S_EL, S_MAC: raddr = ad(i_q, j_q);
			// fetch the pivot so it is on rdata in S_PIV
			S_DIFF, S_PIV: raddr = ad(j_q, j_q);
			S_DIVW: begin
				raddr = ad(j_q, j_q);
				dgo = 1'b0;
			end
			S_WR: begin
				we = 1'b1;
				waddr = ad(i_q, j_q);
				wdata = diff_q;
			end
			S_DRD, S_DMUL: raddr = ad(k_q, k_q);
			S_ORD, S_OUT: raddr = ad(i_q, j_q);
			default: ;
		endcase
		if (st_q == S_PIV && i_q > j_q && rdata != 32'd0) begin
			dgo = 1'b1;
		end
	end

	// S_EL: read a[i][j]; S_RDA/S_RDB: fetch operands; S_MAC accumulate.
	// The read of a[i][j] issued in S_EL lands in the cycle of the next state.
	logic piv_wait_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD;
			order_q <= 4'd4;
			cnt_q <= '0;
			lr_q <= '0;
			lc_q <= '0;
			out_valid <= 1'b0;
			piv_wait_q <= 1'b0;
		end else begin
			out_valid <= 1'b0;
			if (psel && penable && pwrite && paddr == ADDR_ORDER) begin
				order_q <= pwdata[3:0];
				cnt_q <= '0;
				lr_q <= '0;
				lc_q <= '0;
			end
			case (st_q)
				S_LOAD: begin
					if (start) begin
						if (lc_q == 3'(n - 4'd1)) begin
							lc_q <= '0;
							lr_q <= lr_q + 3'd1;
						end else begin
							lc_q <= lc_q + 3'd1;
						end
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q + 7'd1 == 7'(n) * 7'(n)) begin
							st_q <= S_EL;
							i_q <= '0;
							j_q <= '0;
							k_q <= '0;
							pf_q <= 1'b0;
							sat_q <= 1'b0;
							acc_q <= '0;
						end
					end
				end
				S_EL: begin
					st_q <= S_RDA;
				end
				S_RDA: begin
					a_q <= (k_q == 3'd0) ? $signed(rdata) : a_q;
					if (k_q == lim) begin
						st_q <= S_DIFF;
					end else begin
						st_q <= S_RDB;
					end
				end
				S_RDB: begin
					diff_q <= $signed(rdata);
					st_q <= S_MAC;
				end
				S_MAC: begin
					if (!piv_wait_q) begin
						prod_q <= mul_p;
						piv_wait_q <= 1'b1;
					end else begin
						piv_wait_q <= 1'b0;
						acc_q <= acc_q + (prod_q >>> FRAC_BITS);
						k_q <= k_q + 3'd1;
						st_q <= S_RDA;
					end
				end
				S_DIFF: begin
					diff_q <= s0;
					if (ov0) sat_q <= 1'b1;
					st_q <= (i_q > j_q) ? S_PIV : S_WR;
				end
				S_PIV: begin
					st_q <= S_DIVW;
					if (i_q > j_q && rdata == 32'd0) begin
						pf_q <= 1'b1;
						diff_q <= (diff_q > 0) ? SAT_MAX : (diff_q < 0) ? SAT_MIN : 32'sd0;
						st_q <= S_WR;
					end
				end
				S_DIVW: begin
					if (ddone) begin
						diff_q <= s2;
						if (ov2) sat_q <= 1'b1;
						st_q <= S_WR;
					end
				end
				S_WR: begin
					acc_q <= '0;
					k_q <= '0;
					st_q <= S_EL;
					if (j_q == 3'(n - 4'd1)) begin
						j_q <= '0;
						if (i_q == 3'(n - 4'd1)) begin
							i_q <= '0;
							st_q <= S_DRD;
							det_q <= 32'sd1 <<< FRAC_BITS;
						end else begin
							i_q <= i_q + 3'd1;
						end
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
				S_DRD: st_q <= S_DMUL;
				S_DMUL: begin
					if (!piv_wait_q) begin
						prod_q <= mul_p;
						piv_wait_q <= 1'b1;
					end else begin
						piv_wait_q <= 1'b0;
						det_q <= s1;
						if (ov1) sat_q <= 1'b1;
						if (k_q == 3'(n - 4'd1)) begin
							st_q <= S_ORD;
						end else begin
							k_q <= k_q + 3'd1;
							st_q <= S_DRD;
						end
					end
				end
				S_ORD: st_q <= S_OUT;
				S_OUT: begin
					out_valid <= 1'b1;
					lu_value <= $signed(rdata);
					row_index <= i_q;
					col_index <= j_q;
					is_lower <= i_q > j_q;
					last_flag <= 1'b0;
					determinant <= '0;
					zero_pivot <= 1'b0;
					overflow <= 1'b0;
					st_q <= S_ORD;
					if (j_q == 3'(n - 4'd1)) begin
						j_q <= '0;
						if (i_q == 3'(n - 4'd1)) begin
							last_flag <= 1'b1;
							determinant <= det_q;
							zero_pivot <= pf_q;
							overflow <= sat_q;
							st_q <= S_LOAD;
							cnt_q <= '0;
							lr_q <= '0;
							lc_q <= '0;
						end else begin
							i_q <= i_q + 3'd1;
						end
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end
endmodule
